FILE: sv/mlrd_pkg.sv
// Shared types and constants for the MIDI loop recorder and detector.
package mlrd_pkg;

	localparam int MAX_EVENTS = 32;
	localparam int CNT_W      = $clog2(MAX_EVENTS + 1);
	localparam int CHAN_W     = 4;
	localparam int NOTE_W     = 7;
	localparam int VEL_W      = 7;
	localparam int TIME_W     = 32;
	localparam int OFS_W      = 16;
	localparam int STAT_W     = 4;
	localparam int MODE_W     = 2;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_NOTE  = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		STS_NOT_REC      = 4'd0,
		STS_ON_STORED    = 4'd1,
		STS_OFF_MATCHED  = 4'd2,
		STS_LEAD_OFF     = 4'd3,
		STS_OVERFLOW     = 4'd4,
		STS_UNMATCHED    = 4'd5,
		STS_LOOP_PLAYING = 4'd6,
		STS_LOOP_READY   = 4'd7,
		STS_ARMED        = 4'd8
	} status_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_IDLE      = 2'd0,
		MODE_PLAYING   = 2'd1,
		MODE_RECORDING = 2'd2
	} slot_mode_t;

	// One recorded note: pitch, start offset from the base time and length.
	// A length of zero marks the note as still open.
	typedef struct packed {
		logic [NOTE_W-1:0] note;
		logic [OFS_W-1:0]  offset;
		logic [OFS_W-1:0]  length;
	} entry_t;

	// Key broadcast to every cell while a note-off looks for its note-on.
	typedef struct packed {
		logic [NOTE_W-1:0] key_note;
		logic [OFS_W-1:0]  key_rel;
	} seek_t;

	// Outcome reported by a cell that holds the search token.
	typedef struct packed {
		logic hit;
		logic miss;
	} cell_stat_t;

endpackage

FILE: sv/mlrd_if.sv
// Handshake channel interfaces for note events, results and the mode register.

interface mlrd_midi_if import mlrd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [CHAN_W-1:0] midi_channel;
	logic [NOTE_W-1:0] note_number;
	logic [VEL_W-1:0]  note_velocity;
	logic [TIME_W-1:0] time_ms;

	modport source (output valid, cmd, midi_channel, note_number, note_velocity, time_ms,
		input ready);
	modport sink (input valid, cmd, midi_channel, note_number, note_velocity, time_ms,
		output ready);
endinterface

interface mlrd_report_if import mlrd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status_code;
	logic [MODE_W-1:0] slot_state;
	logic [CNT_W-1:0]  event_count;
	logic [CNT_W-1:0]  loop_length;
	logic [OFS_W-1:0]  loop_gap_ms;
	logic [CHAN_W-1:0] loop_channel;

	modport source (output valid, status_code, slot_state, event_count, loop_length,
		loop_gap_ms, loop_channel, input ready);
	modport sink (input valid, status_code, slot_state, event_count, loop_length,
		loop_gap_ms, loop_channel, output ready);
endinterface

interface mlrd_cfg_if ();
	logic valid;
	logic ready;
	logic auto_mode;

	modport source (output valid, auto_mode, input ready);
	modport sink (input valid, auto_mode, output ready);
endinterface

FILE: sv/midi_loop_recorder_detector_core.sv
// Top level of the MIDI loop recorder and detector for one looper slot.
//
// Channels: "midi" takes one transaction per command or note event (a start command
// clears the slot and arms recording, a note event carries channel, note, velocity and
// a millisecond timestamp). "report" gives exactly one result transaction per accepted
// event: a status code and the slot mode, event count, loop length, loop gap and channel
// after that event. "cfg" writes the auto_mode bit and is always ready; write it only
// while the block is idle.
// Results: start commands, note-ons and events that need no search give their result in
// the cycle after acceptance. A note-off walks a token through the row of event cells,
// one cell per cycle from the newest entry backward, until it finds the open entry or
// runs past the stored events; the length of that walk sets the worst-case rate.
// One event is in work at a time. Events that need no search can follow one per cycle:
// the next event is accepted in the cycle in which the previous result leaves the output
// register, and only once any note-off search has finished.
// When the receiver stalls, the result holds in the output register and no further
// event is taken until that result has been accepted.
// Reset: the slot goes idle with no stored events and no loop, auto_mode is 1, and
// the output register is empty. The entry cells are not cleared; only entries below
// the event count are ever looked at.
module midi_loop_recorder_detector_core import mlrd_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	mlrd_midi_if.sink   midi,
	mlrd_report_if.source report,
	mlrd_cfg_if.sink    cfg
);

	// Control sequencer: either waiting for an event or running a note-off search.
	typedef enum logic [1:0] {
		FSM_IDLE = 2'b01,
		FSM_SEEK = 2'b10
	} fsm_t;

	fsm_t              state_q, state_d;
	logic              auto_mode_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  flen_q, flen_d;
	logic [OFS_W-1:0]  fgap_q, fgap_d;
	logic [TIME_W-1:0] base_q, base_d;
	logic [CHAN_W-1:0] chan_q, chan_d;
	slot_mode_t        mode_q, mode_d;
	logic [NOTE_W-1:0] first_note_q, second_note_q;
	seek_t             seek_q;

	logic              in_fire;
	logic              do_out;
	status_t           status_d;
	logic              shift;
	logic              seek_go;
	logic              hit_any;
	logic              miss_any;
	logic [TIME_W-1:0] tdiff;
	entry_t            new_ent;

	entry_t                ent_vec [MAX_EVENTS];
	logic [MAX_EVENTS-1:0] tok_vec;
	logic [MAX_EVENTS-1:0] hit_vec;
	logic [MAX_EVENTS-1:0] miss_vec;
	logic [MAX_EVENTS-1:0] live_vec;

	logic out_valid_q;

	// The configuration register is written whenever a transaction arrives.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_mode_q <= 1'b1;
		end else if (cfg.valid) begin
			auto_mode_q <= cfg.auto_mode;
		end
	end

	// A new event is taken when no search runs and the output register is free or
	// is being emptied in this cycle.
	assign midi.ready = (state_q == FSM_IDLE) && (!out_valid_q || report.ready);
	assign in_fire    = midi.valid && midi.ready;

	// The row of cells: new entries enter at cell 0 and every entry moves one cell
	// on, so cell 0 holds the newest event and cell i the (i+1)-th newest.
	assign new_ent.note   = midi.note_number;
	assign new_ent.offset = tdiff[OFS_W-1:0];
	assign new_ent.length = '0;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_EVENTS; gi++) begin : g_cell
			entry_t     ent_in;
			logic       tok_in;
			cell_stat_t stat;

			if (gi == 0) begin : g_head
				assign ent_in = new_ent;
				assign tok_in = seek_go;
			end else begin : g_body
				assign ent_in = ent_vec[gi-1];
				assign tok_in = tok_vec[gi-1];
			end

			assign live_vec[gi] = CNT_W'(gi) < count_q;

			mlrd_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (shift),
				.ent_in  (ent_in),
				.ent     (ent_vec[gi]),
				.live    (live_vec[gi]),
				.seek    (seek_q),
				.tok_in  (tok_in),
				.tok_out (tok_vec[gi]),
				.stat    (stat)
			);

			assign hit_vec[gi]  = stat.hit;
			assign miss_vec[gi] = stat.miss;
		end
	endgenerate

	// A token that runs past the last cell also means no open entry was found.
	assign hit_any  = |hit_vec;
	assign miss_any = (|miss_vec) || tok_vec[MAX_EVENTS-1];

	// Offset of the incoming event from the base time; the first note-on of a take
	// becomes the base time itself.
	assign tdiff = midi.time_ms - base_d;

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		flen_d   = flen_q;
		fgap_d   = fgap_q;
		base_d   = base_q;
		chan_d   = chan_q;
		mode_d   = mode_q;
		status_d = STS_NOT_REC;
		do_out   = 1'b0;
		shift    = 1'b0;
		seek_go  = 1'b0;

		if (in_fire) begin
			do_out = 1'b1;
			if (midi.cmd == CMD_START) begin
				count_d  = '0;
				flen_d   = '0;
				chan_d   = '0;
				mode_d   = MODE_RECORDING;
				status_d = STS_ARMED;
			end else if (mode_q != MODE_RECORDING) begin
				status_d = STS_NOT_REC;
			end else if (count_q >= CNT_W'(MAX_EVENTS)) begin
				count_d  = '0;
				flen_d   = '0;
				chan_d   = '0;
				mode_d   = MODE_IDLE;
				status_d = STS_OVERFLOW;
			end else if (midi.note_velocity == '0 && count_q == '0) begin
				status_d = STS_LEAD_OFF;
			end else if (midi.note_velocity == '0) begin
				// Note-off: the result waits for the search through the row.
				do_out  = 1'b0;
				seek_go = 1'b1;
				state_d = FSM_SEEK;
			end else begin
				if (count_q == '0) begin
					chan_d = midi.midi_channel;
					base_d = midi.time_ms;
				end
				shift    = 1'b1;
				count_d  = count_q + 1'b1;
				status_d = STS_ON_STORED;
				// With at least four events, the first two notes must match the two
				// newest: the one in cell 0 now and the one arriving.
				if (count_q >= CNT_W'(3) && first_note_q == ent_vec[0].note &&
					second_note_q == midi.note_number) begin
					flen_d = count_q - 1'b1;
					fgap_d = ent_vec[0].offset - ent_vec[1].offset;
					if (auto_mode_q) begin
						mode_d   = MODE_PLAYING;
						status_d = STS_LOOP_PLAYING;
					end else begin
						status_d = STS_LOOP_READY;
					end
				end
			end
		end else if (state_q == FSM_SEEK) begin
			if (hit_any) begin
				do_out   = 1'b1;
				status_d = STS_OFF_MATCHED;
				state_d  = FSM_IDLE;
			end else if (miss_any) begin
				do_out   = 1'b1;
				count_d  = '0;
				flen_d   = '0;
				chan_d   = '0;
				mode_d   = MODE_IDLE;
				status_d = STS_UNMATCHED;
				state_d  = FSM_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			count_q <= '0;
			flen_q  <= '0;
			fgap_q  <= '0;
			base_q  <= '0;
			chan_q  <= '0;
			mode_q  <= MODE_IDLE;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			flen_q  <= flen_d;
			fgap_q  <= fgap_d;
			base_q  <= base_d;
			chan_q  <= chan_d;
			mode_q  <= mode_d;
		end
	end

	// The first two notes of a take are kept aside for the loop compare.
	always_ff @(posedge clk) begin
		if (shift && count_q == '0) begin
			first_note_q <= midi.note_number;
		end
		if (shift && count_q == CNT_W'(1)) begin
			second_note_q <= midi.note_number;
		end
		if (seek_go) begin
			seek_q.key_note <= midi.note_number;
			seek_q.key_rel  <= tdiff[OFS_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_out) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_out) begin
			report.status_code  <= status_d;
			report.slot_state   <= mode_d;
			report.event_count  <= count_d;
			report.loop_length  <= flen_d;
			report.loop_gap_ms  <= fgap_d;
			report.loop_channel <= chan_d;
		end
	end

	assign report.valid = out_valid_q;

	// At most one cell carries the search token or reports its outcome.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec | hit_vec | miss_vec))
		else $error("more than one cell active in the note-off search");

	// Search outcomes appear only while the sequencer waits for them.
	a_seek_only: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_any || miss_any) |-> (state_q == FSM_SEEK))
		else $error("search outcome outside of a note-off search");

	// A running search never coexists with a pending result.
	a_no_out_in_seek: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_SEEK) |-> !out_valid_q)
		else $error("result pending while a search runs");

	// The row never holds more events than it has cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_EVENTS))
		else $error("event count beyond row size");

	// A search starts only with stored events and puts the sequencer into the search state.
	a_token_start: assert property (@(posedge clk) disable iff (!arst_n)
		seek_go |=> (state_q == FSM_SEEK) && (count_q != '0))
		else $error("note-off search started without stored events");

endmodule

FILE: sv/mlrd_cell.sv
// One storage cell of the event row: holds an entry and passes the search token on.
module mlrd_cell import mlrd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  entry_t     ent_in,
	output entry_t     ent,
	input  logic       live,
	input  seek_t      seek,
	input  logic       tok_in,
	output logic       tok_out,
	output cell_stat_t stat
);

	entry_t ent_q;
	logic   tok_q;
	logic   match;

	// The token claims this cell only if it holds a stored, still open entry of the key note.
	assign match = tok_q && live && (ent_q.note == seek.key_note) && (ent_q.length == '0);

	assign stat.hit  = match;
	assign stat.miss = tok_q && !live;
	assign tok_out   = tok_q && live && !match;
	assign ent       = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			ent_q <= ent_in;
		end else if (match) begin
			ent_q.length <= seek.key_rel - ent_q.offset;
		end
	end

endmodule
